// ----- rtl/arp_cache_table_defines.svh -----
// Assertion macros shared by the ARP cache checker.
// No dependencies; include by bare file name.
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// Consequent must hold at every edge where the antecedent holds.
`define ARPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arp cache implication check failed");

// Consequent must hold at the edge after the antecedent held.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arp cache next-cycle check failed");

`endif

// ----- rtl/arpc_pkg.sv -----
// Shared types and constants for the ARP cache table.
// No dependencies; imported by every module of the block.
package arpc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state_e;

    typedef struct packed {
        t_req_e             req_type;
        logic               want_mac;
        logic [IP_W-1:0]    ip_addr;
        logic [MAC_W-1:0]   mac_addr;
    } t_arpc_in;

    typedef struct packed {
        logic               hit;
        logic [MAC_W-1:0]   mac_out;
        logic               insert_ok;
        logic               miss_event;
    } t_arpc_out;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
    } t_slot;

    typedef struct packed {
        logic               shift;
        logic               wr;
        logic               clr;
    } t_cell_ctrl;

endpackage

// ----- rtl/arpc_cell.sv -----
// One slot of the ARP cache ring: valid flag, IPv4 key and MAC value.
// Depends on arpc_pkg.
module arpc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  arpc_pkg::t_cell_ctrl  i_ctrl,
    input  arpc_pkg::t_slot       i_shift_slot,
    input  arpc_pkg::t_slot       i_wr_slot,
    output arpc_pkg::t_slot       o_slot
);
    import arpc_pkg::*;

    logic              r_valid;
    logic [IP_W-1:0]   r_ip;
    logic [MAC_W-1:0]  r_mac;

    // Reset, then clear, win over write and shift; write and shift never coincide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.wr) begin
            r_valid <= i_wr_slot.valid;
        end else if (i_ctrl.shift) begin
            r_valid <= i_shift_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_ip  <= i_wr_slot.ip;
            r_mac <= i_wr_slot.mac;
        end else if (i_ctrl.shift) begin
            r_ip  <= i_shift_slot.ip;
            r_mac <= i_shift_slot.mac;
        end
    end

    assign o_slot = '{valid: r_valid, ip: r_ip, mac: r_mac};

endmodule

// ----- rtl/arp_cache_table.sv -----
// ARP cache table top level: a ring of slot cells, one head comparator, control.
// Depends on arpc_pkg and arpc_cell.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+-----------------
//   in      | to block  | i_in_valid/o_in_stall | t_arpc_in request
//   out     | from block| o_out_valid/i_out_stall| t_arpc_out result
//
// Lookup, insert and remove rotate the whole ring once past the head cell,
// one slot per cycle in ST_SCAN; ST_FINISH then registers the result beat
// once the output register is free or draining.
// Clear drops every valid flag at the accept edge and goes straight to ST_FINISH.
// One request is in flight at a time; the next beat is taken the cycle after the
// result is registered, even while that result is still stalled at the output.
// Reset (synchronous, active low) empties the table and drops all valid flags.
module arp_cache_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  arpc_pkg::t_arpc_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output arpc_pkg::t_arpc_out  o_out_data
);
    import arpc_pkg::*;

    // Control state
    t_state_e          r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    t_arpc_in          r_req, n_req;
    logic              r_found, n_found;
    logic              r_free_seen, n_free_seen;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic              r_out_valid, n_out_valid;
    t_arpc_out         r_out_data, n_out_data;

    // Ring wiring
    t_slot             w_slot    [CAPACITY];
    t_slot             w_ring_in [CAPACITY];
    t_cell_ctrl        w_ctrl    [CAPACITY];
    t_slot             w_head_out;
    t_slot             w_wr_slot;

    logic              w_accept;
    logic              w_match;
    logic              w_fin_go;
    logic              w_do_insert;
    t_arpc_out         w_result;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Head cell is slot 0; every slot passes it once per rotation.
    assign w_match = w_slot[0].valid && (w_slot[0].ip == r_req.ip_addr);

    // A matching remove drops the valid flag as the entry leaves the head.
    always_comb begin
        w_head_out = w_slot[0];
        if (r_req.req_type == REQ_REMOVE && w_match) begin
            w_head_out.valid = 1'b0;
        end
    end

    // Finish may register its result once the output register is free or draining.
    assign w_fin_go    = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);
    assign w_do_insert = w_fin_go && (r_req.req_type == REQ_INSERT) &&
                         !r_found && r_free_seen;
    assign w_wr_slot   = '{valid: 1'b1, ip: r_req.ip_addr, mac: r_req.mac_addr};

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_ring
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_ring_in[gi] = w_head_out;
        end else begin : g_body
            assign w_ring_in[gi] = w_slot[gi+1];
        end

        assign w_ctrl[gi] = '{
            shift: (r_state == ST_SCAN),
            wr:    w_do_insert && (r_free_idx == IDX_W'(gi)),
            clr:   w_accept && (i_in_data.req_type == REQ_CLEAR)
        };

        arpc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl[gi]),
            .i_shift_slot (w_ring_in[gi]),
            .i_wr_slot    (w_wr_slot),
            .o_slot       (w_slot[gi])
        );
    end

    // Result fields from the scan summary.
    always_comb begin
        w_result            = '0;
        w_result.hit        = (r_req.req_type == REQ_LOOKUP) && r_found;
        w_result.mac_out    = ((r_req.req_type == REQ_LOOKUP) && r_found && r_req.want_mac)
                              ? r_mac : '0;
        w_result.insert_ok  = (r_req.req_type == REQ_INSERT) && !r_found && r_free_seen;
        w_result.miss_event = (r_req.req_type == REQ_LOOKUP) && !r_found && r_req.want_mac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan bookkeeping: no reset needed, loaded on accept.
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_req       <= n_req;
        r_found     <= n_found;
        r_free_seen <= n_free_seen;
        r_free_idx  <= n_free_idx;
        r_mac       <= n_mac;
        r_out_data  <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_req       = r_req;
        n_found     = r_found;
        n_free_seen = r_free_seen;
        n_free_idx  = r_free_idx;
        n_mac       = r_mac;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // Drain the output register when the consumer takes the beat.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_req       = i_in_data;
                    n_cnt       = '0;
                    n_found     = 1'b0;
                    n_free_seen = 1'b0;
                    n_free_idx  = '0;
                    n_state     = (i_in_data.req_type == REQ_CLEAR) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_mac   = w_slot[0].mac;
                end
                // Remember the lowest empty slot for a later insert.
                if (!w_slot[0].valid && !r_free_seen) begin
                    n_free_seen = 1'b1;
                    n_free_idx  = r_cnt;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(CAPACITY - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Ring is back in home position; commit insert and hand off result.
                if (w_fin_go) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_result;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checks for the ARP cache table, bound to the top level.
// Depends on arpc_pkg and arp_cache_table_defines.svh.
`include "arp_cache_table_defines.svh"

module arpc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  arpc_pkg::t_arpc_in   i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  arpc_pkg::t_arpc_out  o_out_data
);
    import arpc_pkg::*;

    logic w_in_beat;
    assign w_in_beat = i_in_valid && !o_in_stall && (i_in_data.req_type != REQ_CLEAR);

    // Hold a stalled result beat.
    `ARPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // A result never reports both a hit and a miss.
    `ARPC_ASSERT_IMPL(a_hit_xor_miss, i_clk, i_rst_n, o_out_valid, !(o_out_data.hit && o_out_data.miss_event))
    // A MAC only comes back with a hit, and an insert result has no lookup fields.
    `ARPC_ASSERT_IMPL(a_mac_needs_hit, i_clk, i_rst_n, o_out_valid && (o_out_data.mac_out != '0), o_out_data.hit)
    `ARPC_ASSERT_IMPL(a_insert_alone, i_clk, i_rst_n, o_out_valid && o_out_data.insert_ok, !o_out_data.hit && !o_out_data.miss_event)
    // A scanning request keeps the input side closed on the following cycle.
    `ARPC_ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n, w_in_beat, o_in_stall)

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- dv/tb.sv -----
// Self-checking bench for arp_cache_table: directed table walk, then random traffic.
// Depends on arpc_pkg (beat types, request codes, CAPACITY) and the arp_cache_table RTL.
`timescale 1ns / 1ps

module tb;
    import arpc_pkg::*;

    localparam int NUM_KEYS     = 24;      // key pool a bit larger than the table
    localparam int RAND_PER_PH  = 333;     // three random phases, about 1000 beats
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    // Clock and reset; every block input starts at a known value.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_arpc_in  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_arpc_out o_out_data;

    always #4 i_clk = ~i_clk;

    arp_cache_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Mirror of the table contents. Slot order is not visible at the ports,
    // so fill the lowest free slot and only ever read valid slots.
    logic             tbl_valid [CAPACITY];
    logic [IP_W-1:0]  tbl_ip    [CAPACITY];
    logic [MAC_W-1:0] tbl_mac   [CAPACITY];

    t_arpc_out pending_results [$];   // expected result beats, oldest first

    int mismatch_cnt   = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int lookup_hits    = 0;
    int miss_events    = 0;
    int dup_refusals   = 0;
    int full_refusals  = 0;
    int clears_done    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // One directed row: the request beat, and a hand-written result where the
    // answer is obvious; other rows take the mirror's answer.
    typedef struct {
        t_arpc_in  beat;
        bit        typed;
        t_arpc_out result;
    } t_dir_row;

    t_dir_row dir_rows [$];

    // Apply one request to the mirror and return the result beat it causes.
    function automatic t_arpc_out apply_request(input t_arpc_in beat);
        t_arpc_out res;
        int        found;
        int        free_idx;
        res      = '0;
        found    = -1;
        free_idx = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (tbl_valid[i] && tbl_ip[i] == beat.ip_addr && found < 0)
                found = i;
            if (!tbl_valid[i] && free_idx < 0)
                free_idx = i;
        end
        case (beat.req_type)
            REQ_LOOKUP: begin
                if (found >= 0) begin
                    res.hit = 1'b1;
                    if (beat.want_mac)
                        res.mac_out = tbl_mac[found];
                    lookup_hits++;
                end else if (beat.want_mac) begin
                    res.miss_event = 1'b1;
                    miss_events++;
                end
            end
            REQ_INSERT: begin
                // Refuse duplicates first, then a full table; neither changes state.
                if (found >= 0) begin
                    dup_refusals++;
                end else if (free_idx < 0) begin
                    full_refusals++;
                end else begin
                    tbl_valid[free_idx] = 1'b1;
                    tbl_ip[free_idx]    = beat.ip_addr;
                    tbl_mac[free_idx]   = beat.mac_addr;
                    res.insert_ok       = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (found >= 0)
                    tbl_valid[found] = 1'b0;
            end
            default: begin
                for (int i = 0; i < CAPACITY; i++)
                    tbl_valid[i] = 1'b0;
                clears_done++;
            end
        endcase
        return res;
    endfunction

    task automatic add_row(input t_req_e kind, input bit want, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input bit typed, input bit hit,
                           input logic [MAC_W-1:0] mac_o, input bit ok, input bit miss);
        t_dir_row row;
        row.beat.req_type    = kind;
        row.beat.want_mac    = want;
        row.beat.ip_addr     = ip;
        row.beat.mac_addr    = mac;
        row.typed            = typed;
        row.result.hit       = hit;
        row.result.mac_out   = mac_o;
        row.result.insert_ok = ok;
        row.result.miss_event = miss;
        dir_rows.push_back(row);
    endtask

    // Present one request beat after a random gap and hold it until accepted.
    // The handshake is judged at the falling edge, where every signal is settled,
    // and the beat is taken at the rising edge that follows.
    task automatic send_beat(input t_arpc_in beat, input bit typed, input t_arpc_out fixed);
        t_arpc_out predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        // Advance the mirror on every beat so its state tracks the block.
        predicted = apply_request(beat);
        pending_results.push_back(typed ? fixed : predicted);
        beats_sent++;
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    // Receiver: stall at random with the current phase's rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each result beat that will be taken at the next rising edge
    // against the oldest expectation, field by field.
    always @(negedge i_clk) begin : check_results
        t_arpc_out exp_res;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result beat %h", o_out_data));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_data.hit        !== exp_res.hit       ||
                    o_out_data.mac_out    !== exp_res.mac_out   ||
                    o_out_data.insert_ok  !== exp_res.insert_ok ||
                    o_out_data.miss_event !== exp_res.miss_event) begin
                    report($sformatf({"result %0d: hit %b/%b mac %h/%h ok %b/%b",
                                      " miss %b/%b (expected/actual)"},
                                     results_seen,
                                     exp_res.hit, o_out_data.hit,
                                     exp_res.mac_out, o_out_data.mac_out,
                                     exp_res.insert_ok, o_out_data.insert_ok,
                                     exp_res.miss_event, o_out_data.miss_event));
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [IP_W-1:0] key_pool [NUM_KEYS];
        t_arpc_in        beat;
        logic [63:0]     rnd;
        int              pick;

        for (int i = 0; i < CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
        end

        // Keep the extremes in the pool so they recur throughout the random part.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < NUM_KEYS; i++)
            key_pool[i] = $urandom;

        // Directed table: empty-table lookups, both extremes of key and MAC,
        // duplicate insert, absent remove, fill to capacity, refused insert
        // on a full table, then clear.
        add_row(REQ_LOOKUP, 1'b1, 32'h0000_0000, '0, 1, 0, '0, 0, 1);
        add_row(REQ_LOOKUP, 1'b0, 32'hFFFF_FFFF, '0, 1, 0, '0, 0, 0);
        add_row(REQ_INSERT, 1'b1, 32'h0000_0000, '0, 1, 0, '0, 1, 0);
        add_row(REQ_INSERT, 1'b0, 32'hFFFF_FFFF, '1, 1, 0, '0, 1, 0);
        add_row(REQ_LOOKUP, 1'b1, 32'hFFFF_FFFF, '0, 1, 1, '1, 0, 0);
        add_row(REQ_LOOKUP, 1'b0, 32'h0000_0000, '1, 1, 1, '0, 0, 0);
        add_row(REQ_INSERT, 1'b0, 32'h0000_0000, 48'h5A5A_5A5A_5A5A, 1, 0, '0, 0, 0);
        add_row(REQ_REMOVE, 1'b1, 32'h0000_0001, '1, 1, 0, '0, 0, 0);
        add_row(REQ_REMOVE, 1'b0, 32'h0000_0000, '0, 1, 0, '0, 0, 0);
        add_row(REQ_LOOKUP, 1'b1, 32'h0000_0000, '0, 1, 0, '0, 0, 1);
        for (int k = 0; k < CAPACITY - 1; k++)
            add_row(REQ_INSERT, k[0], 32'h0A00_0000 + 32'(k), 48'h0200_0000_0000 + 48'(k),
                    1, 0, '0, 1, 0);
        add_row(REQ_INSERT, 1'b0, 32'h8000_0000, 48'hA5A5_A5A5_A5A5, 1, 0, '0, 0, 0);
        add_row(REQ_LOOKUP, 1'b1, 32'h0A00_0007, '0, 0, 0, '0, 0, 0);
        add_row(REQ_CLEAR,  1'b1, 32'hFFFF_FFFF, '1, 1, 0, '0, 0, 0);
        add_row(REQ_LOOKUP, 1'b1, 32'hFFFF_FFFF, '0, 1, 0, '0, 0, 1);

        // Hold reset low from time zero, then release it once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 78;
        foreach (dir_rows[r])
            send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].result);

        // Let the pipe run dry before random traffic starts.
        drain_results();

        // Random phases: sender light and receiver heavy, then reversed, then
        // back to back. Most keys come from a small pool so that hits,
        // duplicates and a full table show up often; the rest are fresh.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 78 : 0;
            recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 16 : 0;
            for (int n = 0; n < RAND_PER_PH; n++) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    beat.req_type = REQ_LOOKUP;
                else if (pick < 72)
                    beat.req_type = REQ_INSERT;
                else if (pick < 98)
                    beat.req_type = REQ_REMOVE;
                else
                    beat.req_type = REQ_CLEAR;
                beat.want_mac = 1'($urandom_range(1));
                if ($urandom_range(99) < 85)
                    beat.ip_addr = key_pool[$urandom_range(NUM_KEYS - 1)];
                else
                    beat.ip_addr = $urandom;
                rnd = {$urandom, $urandom};
                beat.mac_addr = rnd[MAC_W-1:0];
                send_beat(beat, 1'b0, '0);
            end
            drain_results();
        end

        // Drop valid, wait out the tail, and let any stray beat show up.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests: %0d lookup hits, %0d miss events, %0d clears",
                 beats_sent, lookup_hits, miss_events, clears_done);
        $display("inserts refused: %0d duplicate key, %0d table full; %0d mismatches",
                 dup_refusals, full_refusals, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arp_cache_table.sv
rtl/arpc_checker.sv
dv/tb.sv
